// ----- hw/rtl/sync_frame_checksum_deframer_defines.svh -----
// Assertion macros for the sync frame checksum deframer.
// No dependencies; included by the RTL files that carry assertions.
`ifndef SYNC_FRAME_CHECKSUM_DEFRAMER_DEFINES_SVH
`define SYNC_FRAME_CHECKSUM_DEFRAMER_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define SFCD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the following cycle
`define SFCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/sfcd_pkg.sv -----
// Shared constants for the sync frame checksum deframer.
// No dependencies; imported by sync_frame_checksum_deframer.
package sfcd_pkg;

   // Field widths
   localparam int ByteW  = 8;
   localparam int SumW   = 16;
   localparam int PhaseW = 2;
   localparam int CsrIdxW = 2;

   typedef logic [ByteW-1:0]  byte_type;
   typedef logic [SumW-1:0]   sum_type;
   typedef logic [PhaseW-1:0] phase_type;
   typedef logic [CsrIdxW-1:0] csr_idx_type;

   // Hunt phase codes
   localparam phase_type PHASE_HUNT   = 2'd0;
   localparam phase_type PHASE_SECOND = 2'd1;
   localparam phase_type PHASE_FRAME  = 2'd2;

   // Register indexes
   localparam csr_idx_type CSR_SYNC_FIRST   = 2'd0;
   localparam csr_idx_type CSR_SYNC_SECOND  = 2'd1;
   localparam csr_idx_type CSR_FRAME_LENGTH = 2'd2;

   // Register reset values and limits
   localparam byte_type SYNC_FIRST_RST   = 8'hEB;
   localparam byte_type SYNC_SECOND_RST  = 8'h90;
   localparam byte_type FRAME_LENGTH_RST = 8'd122;
   localparam byte_type MIN_FRAME_LEN    = 8'd5;

endpackage

// ----- hw/rtl/sync_frame_checksum_deframer.sv -----
// Sync frame checksum deframer: hunts a two-byte header, emits frame bytes with position
// and checks the trailing 16-bit additive checksum. Depends on sfcd_pkg and the defines header.
//
// Takes one received byte per transfer on req_ and returns zero or one result per byte on rsp_.
// Throughput is one byte per clock cycle while rsp_ready does not stall; a byte that produces a
// result shows up on rsp_ once it has moved on from the input register through the step
// logic into the result register. A byte is taken into the input register, the header hunt,
// position count and 16-bit sum update run in one pass of small add/compare logic, and the
// result lands in the result register. The input register lets one more byte be taken while a
// result waits on a stalled rsp_ready. Writes on csr_ (sync_first, sync_second, frame_length;
// lengths below 5 act as 5) belong in idle time.
`include "sync_frame_checksum_deframer_defines.svh"

module sync_frame_checksum_deframer (
   input  logic                  clock,
   input  logic                  reset,
   // Received byte channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sfcd_pkg::byte_type    req_rx_byte,
   // Frame byte channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sfcd_pkg::byte_type    rsp_frame_byte,
   output sfcd_pkg::byte_type    rsp_byte_position,
   output logic                  rsp_frame_end,
   output logic                  rsp_checksum_good,
   // Register write port
   input  logic                  csr_write_en,
   input  sfcd_pkg::csr_idx_type csr_index,
   input  sfcd_pkg::byte_type    csr_write_data
);
   import sfcd_pkg::*;

   // Configuration registers
   byte_type sync_first_ff, sync_second_ff, frame_length_ff;

   // Input stage
   logic     in_valid_ff;
   byte_type in_byte_ff;

   // Deframer state
   phase_type phase_ff, phase_in;
   byte_type  count_ff, count_in;
   sum_type   sum_ff, sum_in;
   logic      low_match_ff, low_match_in;

   // Result stage
   logic     out_valid_ff;
   byte_type out_byte_ff;
   byte_type out_pos_ff;
   logic     out_end_ff;
   logic     out_good_ff;

   // Step outputs
   logic     emit;
   byte_type emit_pos;
   logic     emit_end;
   logic     emit_good;

   logic     out_free;
   logic     fire;
   byte_type len;
   byte_type len_m1;
   byte_type len_m2;
   logic     at_end;

   // Handshake: result register free when empty or being drained
   assign out_free  = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   // Clamp frame length
   assign len    = (frame_length_ff < MIN_FRAME_LEN) ? MIN_FRAME_LEN : frame_length_ff;
   assign len_m1 = len - 8'd1;
   assign len_m2 = len - 8'd2;
   assign at_end = (count_ff >= len_m1);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff   <= SYNC_FIRST_RST;
         sync_second_ff  <= SYNC_SECOND_RST;
         frame_length_ff <= FRAME_LENGTH_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SYNC_FIRST:   sync_first_ff   <= csr_write_data;
            CSR_SYNC_SECOND:  sync_second_ff  <= csr_write_data;
            CSR_FRAME_LENGTH: frame_length_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Advance the header hunt, position count and checksum for the held byte
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      low_match_in = low_match_ff;
      emit         = 1'b0;
      emit_pos     = '0;
      emit_end     = 1'b0;
      emit_good    = 1'b0;
      case (phase_ff)
         PHASE_SECOND: begin
            if (in_byte_ff == sync_second_ff) begin
               phase_in = PHASE_FRAME;
               sum_in   = sum_ff + {8'd0, in_byte_ff};
               count_in = 8'd2;
               emit     = 1'b1;
               emit_pos = 8'd1;
            end else if (in_byte_ff == sync_first_ff) begin
               // restart on a fresh first header byte
               phase_in     = PHASE_SECOND;
               sum_in       = {8'd0, in_byte_ff};
               count_in     = 8'd1;
               low_match_in = 1'b0;
               emit         = 1'b1;
            end else begin
               phase_in = PHASE_HUNT;
               count_in = '0;
            end
         end
         PHASE_FRAME: begin
            emit     = 1'b1;
            emit_pos = count_ff;
            if (at_end) begin
               emit_end     = 1'b1;
               emit_good    = low_match_ff && (in_byte_ff == sum_ff[15:8]);
               phase_in     = PHASE_HUNT;
               count_in     = '0;
               sum_in       = '0;
               low_match_in = 1'b0;
            end else begin
               if (count_ff == len_m2) begin
                  low_match_in = (in_byte_ff == sum_ff[7:0]);
               end else begin
                  sum_in = sum_ff + {8'd0, in_byte_ff};
               end
               count_in = count_ff + 8'd1;
            end
         end
         default: begin
            // hunting; the unused code falls here too
            phase_in = PHASE_HUNT;
            if (in_byte_ff == sync_first_ff) begin
               phase_in     = PHASE_SECOND;
               sum_in       = {8'd0, in_byte_ff};
               count_in     = 8'd1;
               low_match_in = 1'b0;
               emit         = 1'b1;
            end
         end
      endcase
   end

   // Hold the input register until its byte is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Update deframer state on each processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_HUNT;
         count_ff     <= '0;
         sum_ff       <= '0;
         low_match_ff <= 1'b0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         low_match_ff <= low_match_in;
      end
   end

   // Load or drain the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= fire && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && emit) begin
         out_byte_ff <= in_byte_ff;
         out_pos_ff  <= emit_pos;
         out_end_ff  <= emit_end;
         out_good_ff <= emit_good;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_frame_byte    = out_byte_ff;
   assign rsp_byte_position = out_pos_ff;
   assign rsp_frame_end     = out_end_ff;
   assign rsp_checksum_good = out_good_ff;

   // Checks
   `SFCD_ASSERT_SAME(a_good_only_at_end, clock, reset,
      rsp_valid && rsp_checksum_good, rsp_frame_end, "checksum_good without frame_end")
   `SFCD_ASSERT_SAME(a_end_position, clock, reset,
      rsp_valid && rsp_frame_end, rsp_byte_position >= 8'd4, "frame ended too early")
   `SFCD_ASSERT_SAME(a_hunt_count_zero, clock, reset,
      phase_ff == PHASE_HUNT, count_ff == 8'd0, "count not cleared while hunting")
   `SFCD_ASSERT_SAME(a_frame_count, clock, reset,
      phase_ff == PHASE_FRAME, count_ff >= 8'd2, "frame position below payload start")
   `SFCD_ASSERT_NEXT(a_end_returns_hunt, clock, reset,
      fire && phase_ff == PHASE_FRAME && at_end, phase_ff == PHASE_HUNT,
      "no return to hunting after frame end")

endmodule
